// ===== hdl/gap_pkg.sv =====
package gap_pkg;

  typedef struct packed {
    logic [2:0] start_row;
    logic [2:0] start_col;
    logic [2:0] goal_row;
    logic [2:0] goal_col;
  } in_item_t;

  typedef struct packed {
    logic [2:0] cell_row;
    logic [2:0] cell_col;
    logic [1:0] outcome;
    logic       last_item;
  } out_item_t;

  localparam logic [1:0] OUTCOME_PATH     = 2'd0;
  localparam logic [1:0] OUTCOME_NO_PATH  = 2'd1;
  localparam logic [1:0] OUTCOME_OVERFLOW = 2'd2;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKED_MAP = 2'd2;

  localparam int CELL_W      = 6;
  localparam int CHAIN_DEPTH = 64;
  localparam int CHAIN_IDX_W = 6;
  localparam int CHAIN_CNT_W = 7;

  // 8-connected moves; the first four are orthogonal
  localparam logic signed [1:0] MOVE_DR [8] = '{2'sd1, -2'sd1, 2'sd0, 2'sd0,
                                                2'sd1, 2'sd1, -2'sd1, -2'sd1};
  localparam logic signed [1:0] MOVE_DC [8] = '{2'sd0, 2'sd0, 2'sd1, -2'sd1,
                                                2'sd1, -2'sd1, 2'sd1, -2'sd1};

  typedef logic [4:0] op_t;
  localparam op_t OP_NOP      = 5'd0;
  localparam op_t OP_START    = 5'd1;
  localparam op_t OP_INIT     = 5'd2;
  localparam op_t OP_POP_RD   = 5'd3;
  localparam op_t OP_POP_LD   = 5'd4;
  localparam op_t OP_SIFT_RD  = 5'd5;
  localparam op_t OP_SIFT_MV  = 5'd6;
  localparam op_t OP_SIFT_END = 5'd7;
  localparam op_t OP_NODE     = 5'd8;
  localparam op_t OP_TR_INIT  = 5'd9;
  localparam op_t OP_NB_RD    = 5'd10;
  localparam op_t OP_NB_SKIP  = 5'd11;
  localparam op_t OP_INSERT   = 5'd12;
  localparam op_t OP_PUSH_RD  = 5'd13;
  localparam op_t OP_PUSH_MV  = 5'd14;
  localparam op_t OP_PUSH_PUT = 5'd15;
  localparam op_t OP_TR_RD    = 5'd16;
  localparam op_t OP_TR_WR    = 5'd17;
  localparam op_t OP_EM_RD    = 5'd18;
  localparam op_t OP_EM_OUT   = 5'd19;
  localparam op_t OP_OUT_NP   = 5'd20;
  localparam op_t OP_OUT_OV   = 5'd21;

  typedef struct packed {
    logic sift_leaf;
    logic sift_stop;
    logic at_goal;
    logic nb_ok;
    logic nb_better;
    logic pool_full;
    logic d_last;
    logic push_root;
    logic push_stop;
    logic heap_empty;
    logic tr_end;
    logic k_zero;
    logic out_free;
  } dp_status_t;

  // rounded Euclidean length in fixed point, evaluated on constants only
  function automatic longint unsigned dist_q(int ar, int ac, int frac);
    longint unsigned n;
    longint unsigned res;
    longint unsigned bit_v;
    n = longint'(ar * ar + ac * ac) << (2 * frac);
    res = 0;
    bit_v = 64'd1 << 62;
    for (int j = 0; j < 32; j++) begin
      if (n >= res + bit_v) begin
        n = n - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    if (n > res) res = res + 1;
    return res;
  endfunction

endpackage

// ===== hdl/gap_datapath.sv =====
module gap_datapath import gap_pkg::*; #(
  parameter int GRID_SIDE      = 8,
  parameter int POOL_DEPTH     = 512,
  parameter int COST_FRAC_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  op_t                  op,
  output dp_status_t           status,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  localparam int IDX_W  = $clog2(POOL_DEPTH);
  localparam int CNT_W  = IDX_W + 1;
  localparam int COST_W = COST_FRAC_BITS + 9;
  localparam int HEAP_W = COST_W + IDX_W;
  localparam int POOL_W = CELL_W + IDX_W + COST_W;

  logic [COST_W-1:0] htab [64];
  for (genvar a = 0; a < 8; a++) begin : g_hr
    for (genvar b = 0; b < 8; b++) begin : g_hc
      assign htab[a*8+b] = COST_W'(dist_q(a, b, COST_FRAC_BITS));
    end
  end

  // configuration
  logic [3:0]  rows_r, cols_r;
  logic [63:0] blocked_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r    <= 4'd8;
      cols_r    <= 4'd8;
      blocked_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GRID_ROWS:   rows_r    <= cfg_data[3:0];
        CFG_GRID_COLS:   cols_r    <= cfg_data[3:0];
        CFG_BLOCKED_MAP: blocked_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // memories
  logic [HEAP_W-1:0] heap_mem [POOL_DEPTH];
  logic [POOL_W-1:0] pool_mem [POOL_DEPTH];
  logic [COST_W-1:0] best_mem [64];
  logic [CELL_W-1:0] chain_mem [CHAIN_DEPTH];
  logic [HEAP_W-1:0] rda_r, rdb_r;
  logic [POOL_W-1:0] pool_rd_r;
  logic [COST_W-1:0] best_rd_r;
  logic [CELL_W-1:0] chain_rd_r;

  logic              heap_we, heap_re;
  logic [IDX_W-1:0]  heap_wa, heap_ra, heap_rb;
  logic [HEAP_W-1:0] heap_wd;
  logic              pool_we, pool_re;
  logic [IDX_W-1:0]  pool_wa, pool_ra;
  logic [POOL_W-1:0] pool_wd;
  logic              best_we, best_re;
  logic [CELL_W-1:0] best_wa, best_ra;
  logic [COST_W-1:0] best_wd;
  logic              chain_we, chain_re;
  logic [CHAIN_IDX_W-1:0] chain_wa, chain_ra;
  logic [CELL_W-1:0] chain_wd;

  always_ff @(posedge clk) begin
    if (heap_we) heap_mem[heap_wa] <= heap_wd;
    if (heap_re) begin
      rda_r <= heap_mem[heap_ra];
      rdb_r <= heap_mem[heap_rb];
    end
  end

  always_ff @(posedge clk) begin
    if (pool_we) pool_mem[pool_wa] <= pool_wd;
    if (pool_re) pool_rd_r <= pool_mem[pool_ra];
  end

  always_ff @(posedge clk) begin
    if (best_we) best_mem[best_wa] <= best_wd;
    if (best_re) best_rd_r <= best_mem[best_ra];
  end

  always_ff @(posedge clk) begin
    if (chain_we) chain_mem[chain_wa] <= chain_wd;
    if (chain_re) chain_rd_r <= chain_mem[chain_ra];
  end

  // working registers
  in_item_t          q_r, q_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt, pc_r, pc_nxt;
  logic [HEAP_W-1:0] top_r, top_nxt, last_r, last_nxt, node_e_r, node_e_nxt;
  logic [IDX_W-1:0]  i_r, i_nxt, l_r, l_nxt, cur_idx_r, cur_idx_nxt;
  logic [IDX_W-1:0]  pi_r, pi_nxt, node_r, node_nxt;
  logic [CELL_W-1:0] cur_cell_r, cur_cell_nxt, nidx_r, nidx_nxt;
  logic [COST_W-1:0] cur_g_r, cur_g_nxt, tg_r, tg_nxt;
  logic [2:0]        d_r, d_nxt;
  logic [CHAIN_CNT_W-1:0] n_r, n_nxt;
  logic [CHAIN_IDX_W-1:0] k_r, k_nxt;
  logic [63:0]       known_r, known_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;

  // derived values
  logic [CNT_W-1:0]  l_full;
  logic              r_ok, m_sel;
  logic [HEAP_W-1:0] m_e;
  logic [IDX_W-1:0]  m_idx, pp;
  logic [CELL_W-1:0] rd_cell, nb_idx, start_cell, goal_cell;
  logic [IDX_W-1:0]  rd_parent;
  logic [COST_W-1:0] rd_g, step_cost, tg_c, h_start, h_new;
  logic [3:0]        rows_eff, cols_eff;
  logic signed [4:0] nr, nc;
  logic              in_area;
  logic signed [3:0] dsr, dsc, dnr, dnc;
  logic [2:0]        asr, asc, anr, anc;
  logic              out_load;
  out_item_t         out_val;

  assign start_cell = {q_r.start_row, q_r.start_col};
  assign goal_cell  = {q_r.goal_row, q_r.goal_col};
  assign l_full = {i_r, 1'b1};
  assign r_ok   = (CNT_W'(l_r) + CNT_W'(1)) < cnt_r;
  assign m_sel  = r_ok && (rdb_r < rda_r);
  assign m_e    = m_sel ? rdb_r : rda_r;
  assign m_idx  = m_sel ? (l_r + IDX_W'(1)) : l_r;
  assign pp     = (pi_r - IDX_W'(1)) >> 1;

  assign rd_cell   = pool_rd_r[POOL_W-1 -: CELL_W];
  assign rd_parent = pool_rd_r[IDX_W+COST_W-1 -: IDX_W];
  assign rd_g      = pool_rd_r[COST_W-1:0];

  assign rows_eff = (rows_r > 4'(GRID_SIDE)) ? 4'(GRID_SIDE) : rows_r;
  assign cols_eff = (cols_r > 4'(GRID_SIDE)) ? 4'(GRID_SIDE) : cols_r;
  assign nr = $signed({2'b00, cur_cell_r[5:3]}) + 5'(MOVE_DR[d_r]);
  assign nc = $signed({2'b00, cur_cell_r[2:0]}) + 5'(MOVE_DC[d_r]);
  assign in_area = (nr >= 0) && (nr < $signed({1'b0, rows_eff}))
                && (nc >= 0) && (nc < $signed({1'b0, cols_eff}));
  assign nb_idx = {nr[2:0], nc[2:0]};
  assign step_cost = d_r[2] ? htab[9] : htab[1];
  assign tg_c = cur_g_r + step_cost;

  assign dsr = $signed({1'b0, q_r.goal_row}) - $signed({1'b0, q_r.start_row});
  assign dsc = $signed({1'b0, q_r.goal_col}) - $signed({1'b0, q_r.start_col});
  assign dnr = $signed({1'b0, q_r.goal_row}) - $signed({1'b0, nidx_r[5:3]});
  assign dnc = $signed({1'b0, q_r.goal_col}) - $signed({1'b0, nidx_r[2:0]});
  assign asr = dsr[3] ? 3'(-dsr) : dsr[2:0];
  assign asc = dsc[3] ? 3'(-dsc) : dsc[2:0];
  assign anr = dnr[3] ? 3'(-dnr) : dnr[2:0];
  assign anc = dnc[3] ? 3'(-dnc) : dnc[2:0];
  assign h_start = htab[{asr, asc}];
  assign h_new   = htab[{anr, anc}];

  always_comb begin
    status.sift_leaf  = l_full >= cnt_r;
    status.sift_stop  = !(m_e < last_r);
    status.at_goal    = cur_cell_r == goal_cell;
    status.nb_ok      = in_area && !blocked_r[nb_idx];
    status.nb_better  = !(known_r[nidx_r] && (tg_r >= best_rd_r));
    status.pool_full  = pc_r >= CNT_W'(POOL_DEPTH);
    status.d_last     = d_r == 3'd7;
    status.push_root  = pi_r == '0;
    status.push_stop  = !(node_e_r < rda_r);
    status.heap_empty = cnt_r == '0;
    status.tr_end     = (node_r == '0) || (n_r + 1'b1 >= CHAIN_CNT_W'(CHAIN_DEPTH));
    status.k_zero     = k_r == '0;
    status.out_free   = !out_valid_r || out_ready;
  end

  always_comb begin
    q_nxt = q_r; cnt_nxt = cnt_r; pc_nxt = pc_r; top_nxt = top_r; last_nxt = last_r;
    node_e_nxt = node_e_r; i_nxt = i_r; l_nxt = l_r; cur_idx_nxt = cur_idx_r;
    pi_nxt = pi_r; node_nxt = node_r; cur_cell_nxt = cur_cell_r; nidx_nxt = nidx_r;
    cur_g_nxt = cur_g_r; tg_nxt = tg_r; d_nxt = d_r; n_nxt = n_r; k_nxt = k_r;
    known_nxt = known_r;
    heap_we = 1'b0; heap_wa = '0; heap_wd = '0;
    heap_re = 1'b0; heap_ra = '0; heap_rb = '0;
    pool_we = 1'b0; pool_wa = '0; pool_wd = '0; pool_re = 1'b0; pool_ra = '0;
    best_we = 1'b0; best_wa = '0; best_wd = '0; best_re = 1'b0; best_ra = '0;
    chain_we = 1'b0; chain_wa = '0; chain_wd = '0; chain_re = 1'b0; chain_ra = '0;
    out_load = 1'b0; out_val = '0;
    unique case (op)
      OP_START: begin
        q_nxt = in_data;
        known_nxt = '0;
      end
      OP_INIT: begin
        pool_we = 1'b1; pool_wa = '0; pool_wd = {start_cell, {IDX_W{1'b0}}, {COST_W{1'b0}}};
        heap_we = 1'b1; heap_wa = '0; heap_wd = {h_start, {IDX_W{1'b0}}};
        best_we = 1'b1; best_wa = start_cell; best_wd = '0;
        known_nxt[start_cell] = 1'b1;
        cnt_nxt = CNT_W'(1);
        pc_nxt  = CNT_W'(1);
      end
      OP_POP_RD: begin
        heap_re = 1'b1; heap_ra = '0; heap_rb = IDX_W'(cnt_r - CNT_W'(1));
      end
      OP_POP_LD: begin
        top_nxt = rda_r; last_nxt = rdb_r;
        cnt_nxt = cnt_r - CNT_W'(1);
        i_nxt = '0;
      end
      OP_SIFT_RD: begin
        heap_re = 1'b1;
        heap_ra = l_full[IDX_W-1:0];
        heap_rb = IDX_W'(l_full + CNT_W'(1));
        l_nxt = l_full[IDX_W-1:0];
      end
      OP_SIFT_MV: begin
        heap_we = 1'b1; heap_wa = i_r; heap_wd = m_e;
        i_nxt = m_idx;
      end
      OP_SIFT_END: begin
        heap_we = cnt_r != '0; heap_wa = i_r; heap_wd = last_r;
        pool_re = 1'b1; pool_ra = top_r[IDX_W-1:0];
      end
      OP_NODE: begin
        cur_cell_nxt = rd_cell; cur_g_nxt = rd_g; cur_idx_nxt = top_r[IDX_W-1:0];
        d_nxt = '0;
      end
      OP_TR_INIT: begin
        node_nxt = cur_idx_r; n_nxt = '0;
      end
      OP_NB_RD: begin
        best_re = 1'b1; best_ra = nb_idx;
        tg_nxt = tg_c; nidx_nxt = nb_idx;
      end
      OP_NB_SKIP: d_nxt = d_r + 3'd1;
      OP_INSERT: begin
        pool_we = 1'b1; pool_wa = pc_r[IDX_W-1:0]; pool_wd = {nidx_r, cur_idx_r, tg_r};
        best_we = 1'b1; best_wa = nidx_r; best_wd = tg_r;
        known_nxt[nidx_r] = 1'b1;
        node_e_nxt = {tg_r + h_new, pc_r[IDX_W-1:0]};
        pi_nxt = cnt_r[IDX_W-1:0];
        cnt_nxt = cnt_r + CNT_W'(1);
        pc_nxt = pc_r + CNT_W'(1);
      end
      OP_PUSH_RD: begin
        heap_re = 1'b1; heap_ra = pp; heap_rb = pp;
      end
      OP_PUSH_MV: begin
        heap_we = 1'b1; heap_wa = pi_r; heap_wd = rda_r;
        pi_nxt = pp;
      end
      OP_PUSH_PUT: begin
        heap_we = 1'b1; heap_wa = pi_r; heap_wd = node_e_r;
      end
      OP_TR_RD: begin
        pool_re = 1'b1; pool_ra = node_r;
      end
      OP_TR_WR: begin
        chain_we = 1'b1; chain_wa = n_r[CHAIN_IDX_W-1:0]; chain_wd = rd_cell;
        n_nxt = n_r + 1'b1;
        node_nxt = rd_parent;
        k_nxt = n_r[CHAIN_IDX_W-1:0];
      end
      OP_EM_RD: begin
        chain_re = 1'b1; chain_ra = k_r;
      end
      OP_EM_OUT: begin
        out_load = 1'b1;
        out_val = '{cell_row: chain_rd_r[5:3], cell_col: chain_rd_r[2:0],
                    outcome: OUTCOME_PATH, last_item: k_r == '0};
        k_nxt = k_r - 1'b1;
      end
      OP_OUT_NP: begin
        out_load = 1'b1;
        out_val = '{cell_row: 3'd0, cell_col: 3'd0, outcome: OUTCOME_NO_PATH, last_item: 1'b1};
      end
      OP_OUT_OV: begin
        out_load = 1'b1;
        out_val = '{cell_row: 3'd0, cell_col: 3'd0, outcome: OUTCOME_OVERFLOW, last_item: 1'b1};
      end
      default: ;
    endcase
    out_nxt = out_load ? out_val : out_r;
    out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt; cnt_r <= cnt_nxt; pc_r <= pc_nxt; top_r <= top_nxt; last_r <= last_nxt;
    node_e_r <= node_e_nxt; i_r <= i_nxt; l_r <= l_nxt; cur_idx_r <= cur_idx_nxt;
    pi_r <= pi_nxt; node_r <= node_nxt; cur_cell_r <= cur_cell_nxt; nidx_r <= nidx_nxt;
    cur_g_r <= cur_g_nxt; tg_r <= tg_nxt; d_r <= d_nxt; n_r <= n_nxt; k_r <= k_nxt;
    known_r <= known_nxt; out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== hdl/gap_ctrl.sv =====
module gap_ctrl import gap_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output op_t        op
);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_INIT     = 5'd1;
  localparam logic [4:0] S_POP0     = 5'd2;
  localparam logic [4:0] S_POP1     = 5'd3;
  localparam logic [4:0] S_SIFT_RD  = 5'd4;
  localparam logic [4:0] S_SIFT_CMP = 5'd5;
  localparam logic [4:0] S_SIFT_END = 5'd6;
  localparam logic [4:0] S_NODE     = 5'd7;
  localparam logic [4:0] S_GOALCK   = 5'd8;
  localparam logic [4:0] S_NB_CHK   = 5'd9;
  localparam logic [4:0] S_NB_BEST  = 5'd10;
  localparam logic [4:0] S_PUSH_RD  = 5'd11;
  localparam logic [4:0] S_PUSH_CMP = 5'd12;
  localparam logic [4:0] S_NB_NEXT  = 5'd13;
  localparam logic [4:0] S_AFTER    = 5'd14;
  localparam logic [4:0] S_TR_RD    = 5'd15;
  localparam logic [4:0] S_TR_WR    = 5'd16;
  localparam logic [4:0] S_EM_RD    = 5'd17;
  localparam logic [4:0] S_EM_OUT   = 5'd18;
  localparam logic [4:0] S_EMIT_NP  = 5'd19;
  localparam logic [4:0] S_EMIT_OV  = 5'd20;

  logic [4:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    op = OP_NOP;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op = OP_START; state_nxt = S_INIT;
        end
      end
      S_INIT:    begin op = OP_INIT;   state_nxt = S_POP0; end
      S_POP0:    begin op = OP_POP_RD; state_nxt = S_POP1; end
      S_POP1:    begin op = OP_POP_LD; state_nxt = S_SIFT_RD; end
      S_SIFT_RD: begin
        if (status.sift_leaf) begin
          state_nxt = S_SIFT_END;
        end else begin
          op = OP_SIFT_RD; state_nxt = S_SIFT_CMP;
        end
      end
      S_SIFT_CMP: begin
        if (status.sift_stop) begin
          state_nxt = S_SIFT_END;
        end else begin
          op = OP_SIFT_MV; state_nxt = S_SIFT_RD;
        end
      end
      S_SIFT_END: begin op = OP_SIFT_END; state_nxt = S_NODE; end
      S_NODE:     begin op = OP_NODE;     state_nxt = S_GOALCK; end
      S_GOALCK: begin
        if (status.at_goal) begin
          op = OP_TR_INIT; state_nxt = S_TR_RD;
        end else begin
          state_nxt = S_NB_CHK;
        end
      end
      S_NB_CHK: begin
        if (status.nb_ok) begin
          op = OP_NB_RD; state_nxt = S_NB_BEST;
        end else begin
          state_nxt = S_NB_NEXT;
        end
      end
      S_NB_BEST: begin
        priority if (!status.nb_better) begin
          state_nxt = S_NB_NEXT;
        end else if (status.pool_full) begin
          state_nxt = S_EMIT_OV;
        end else begin
          op = OP_INSERT; state_nxt = S_PUSH_RD;
        end
      end
      S_PUSH_RD: begin
        if (status.push_root) begin
          op = OP_PUSH_PUT; state_nxt = S_NB_NEXT;
        end else begin
          op = OP_PUSH_RD; state_nxt = S_PUSH_CMP;
        end
      end
      S_PUSH_CMP: begin
        if (status.push_stop) begin
          op = OP_PUSH_PUT; state_nxt = S_NB_NEXT;
        end else begin
          op = OP_PUSH_MV; state_nxt = S_PUSH_RD;
        end
      end
      S_NB_NEXT: begin
        op = OP_NB_SKIP;
        state_nxt = status.d_last ? S_AFTER : S_NB_CHK;
      end
      S_AFTER: state_nxt = status.heap_empty ? S_EMIT_NP : S_POP0;
      S_TR_RD: begin op = OP_TR_RD; state_nxt = S_TR_WR; end
      S_TR_WR: begin
        op = OP_TR_WR;
        state_nxt = status.tr_end ? S_EM_RD : S_TR_RD;
      end
      S_EM_RD: begin op = OP_EM_RD; state_nxt = S_EM_OUT; end
      S_EM_OUT: begin
        if (status.out_free) begin
          op = OP_EM_OUT;
          state_nxt = status.k_zero ? S_IDLE : S_EM_RD;
        end
      end
      S_EMIT_NP: begin
        if (status.out_free) begin
          op = OP_OUT_NP; state_nxt = S_IDLE;
        end
      end
      S_EMIT_OV: begin
        if (status.out_free) begin
          op = OP_OUT_OV; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hdl/grid_astar_path_planner.sv =====
// A* path planner over an occupancy grid of up to 8 x 8 cells, 8-connected.
// Input channel (in_valid/in_ready/in_data): one transaction is one query,
// start and goal cell. Result channel (out_valid/out_ready/out_data): the
// path from start to goal, one cell per transaction, last_item on the goal
// cell; or a single transaction with outcome no-path or pool overflow.
// Configuration (cfg_we/cfg_index/cfg_data): grid rows, grid columns and
// the blocked-cell map; write only while no query is in flight.
// Flow: a query first sets up the start node; each heap pop then reads the
// root and the last entry and sifts down, and each neighbor is checked,
// its best cost read and, if better, inserted and pushed; every heap level
// of the sift or the push costs a registered read and a compare. The path is
// traced back into a chain buffer, then streams out one cell at a time while
// the receiver takes them.
// One query is worked at a time; the next one is accepted once the last
// result sits in the output register, even if the receiver has not taken it.
// A stalled receiver holds the output register and pauses the path readout.
// Reset (rst_n, synchronous) restores 8 x 8 with no blocked cells and drops
// any query in flight; node pool and heap need no clearing.
module grid_astar_path_planner import gap_pkg::*; #(
  parameter int GRID_SIDE      = 8,
  parameter int POOL_DEPTH     = 512,
  parameter int COST_FRAC_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  op_t        op;
  dp_status_t status;

  // sequence the search
  gap_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .op       (op)
  );

  // heap, node pool, cost table and output register
  gap_datapath #(
    .GRID_SIDE      (GRID_SIDE),
    .POOL_DEPTH     (POOL_DEPTH),
    .COST_FRAC_BITS (COST_FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .status    (status),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

// ===== tb/sv/tb_grid_astar_path_planner.sv =====
`timescale 1ns / 100ps

module tb_grid_astar_path_planner;
  import gap_pkg::*;

  localparam int POOL_N      = 512;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int SETTLE      = 40;
  // index 3 lies past the register list; the block must ignore it
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_item_t            out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [63:0]          cfg_data;

  grid_astar_path_planner u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Shadow copy of the configuration registers
  int unsigned shadow_rows;
  int unsigned shadow_cols;
  logic [63:0] shadow_blocked;

  // Search scratch for the path planner model
  int unsigned nd_cell [POOL_N];
  int unsigned nd_par  [POOL_N];
  int unsigned nd_g    [POOL_N];
  int unsigned nd_f    [POOL_N];
  int unsigned open_q  [POOL_N];
  int unsigned cell_g  [64];
  bit          cell_seen [64];
  int unsigned pool_used;
  int unsigned open_used;

  // Cells still owed by the block, oldest first
  out_item_t expected_cells[$];

  int errors;
  int unsigned cycles;
  int gap_pct;
  int stall_pct;

  // Append one owed cell
  function automatic void owe_cell(out_item_t c);
    expected_cells = {expected_cells, c};
  endfunction

  // Rounded Euclidean length in Q8.8
  function automatic int unsigned eucl_q(int dr, int dc);
    longint unsigned n;
    longint unsigned s;
    n = longint'(dr * dr + dc * dc) << 16;
    s = 0;
    for (int b = 12; b >= 0; b--) begin
      if ((s + (64'd1 << b)) * (s + (64'd1 << b)) <= n) s = s + (64'd1 << b);
    end
    if (n - s * s > s) s = s + 1;
    return int'(s);
  endfunction

  function automatic bit ahead(int unsigned a, int unsigned b);
    return nd_f[a] < nd_f[b] || (nd_f[a] == nd_f[b] && a < b);
  endfunction

  function automatic void open_push(int unsigned node);
    int unsigned i;
    int unsigned p;
    i = open_used;
    open_used++;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (!ahead(node, open_q[p])) break;
      open_q[i] = open_q[p];
      i = p;
    end
    open_q[i] = node;
  endfunction

  function automatic int unsigned open_pop();
    int unsigned top;
    int unsigned tail;
    int unsigned i;
    int unsigned l;
    int unsigned m;
    top = open_q[0];
    open_used--;
    tail = open_q[open_used];
    i = 0;
    forever begin
      l = 2 * i + 1;
      if (l >= open_used) break;
      m = l;
      if (l + 1 < open_used && ahead(open_q[l + 1], open_q[l])) m = l + 1;
      if (!ahead(open_q[m], tail)) break;
      open_q[i] = open_q[m];
      i = m;
    end
    if (open_used > 0) open_q[i] = tail;
    return top;
  endfunction

  // Run A* for one query and queue the cells it must produce
  function automatic void plan_path(in_item_t q);
    int sr, sc, gr, gc, rows, cols;
    int cr, cc, nr, nc, idx, n;
    int unsigned cur, node, tg;
    int unsigned chain[64];
    sr = q.start_row;
    sc = q.start_col;
    gr = q.goal_row;
    gc = q.goal_col;
    rows = shadow_rows > 8 ? 8 : shadow_rows;
    cols = shadow_cols > 8 ? 8 : shadow_cols;
    for (int k = 0; k < 64; k++) cell_seen[k] = 1'b0;
    nd_cell[0] = sr * 8 + sc;
    nd_par[0] = 0;
    nd_g[0] = 0;
    nd_f[0] = eucl_q(gr - sr, gc - sc);
    pool_used = 1;
    open_used = 0;
    open_push(0);
    cell_g[sr * 8 + sc] = 0;
    cell_seen[sr * 8 + sc] = 1'b1;
    while (open_used > 0) begin
      cur = open_pop();
      cr = nd_cell[cur] >> 3;
      cc = nd_cell[cur] & 7;
      if (cr == gr && cc == gc) begin
        n = 0;
        node = cur;
        forever begin
          chain[n] = nd_cell[node];
          n++;
          if (node == 0 || n >= 64) break;
          node = nd_par[node];
        end
        for (int k = 0; k < n; k++) begin
          owe_cell('{cell_row: 3'(chain[n-1-k] >> 3), cell_col: 3'(chain[n-1-k] & 7),
                     outcome: OUTCOME_PATH, last_item: (k == n - 1)});
        end
        return;
      end
      for (int d = 0; d < 8; d++) begin
        nr = cr + MOVE_DR[d];
        nc = cc + MOVE_DC[d];
        if (nr < 0 || nr >= rows || nc < 0 || nc >= cols) continue;
        idx = nr * 8 + nc;
        if (shadow_blocked[idx]) continue;
        tg = nd_g[cur] + eucl_q(MOVE_DR[d], MOVE_DC[d]);
        if (cell_seen[idx] && tg >= cell_g[idx]) continue;
        if (pool_used >= POOL_N) begin
          owe_cell('{cell_row: 3'd0, cell_col: 3'd0,
                     outcome: OUTCOME_OVERFLOW, last_item: 1'b1});
          return;
        end
        node = pool_used;
        pool_used++;
        nd_cell[node] = idx;
        nd_par[node] = cur;
        nd_g[node] = tg;
        nd_f[node] = tg + eucl_q(gr - nr, gc - nc);
        open_push(node);
        cell_g[idx] = tg;
        cell_seen[idx] = 1'b1;
      end
    end
    owe_cell('{cell_row: 3'd0, cell_col: 3'd0, outcome: OUTCOME_NO_PATH,
               last_item: 1'b1});
  endfunction

  // Directed table: config writes and queries; a known result is typed in
  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [63:0]          data;
    in_item_t             q;
    bit                   known;
    out_item_t            res;
  } step_row_t;

  step_row_t directed[$];

  function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
    step_row_t row;
    row = '{is_cfg: 1'b1, idx: idx, data: data, q: '0, known: 1'b0, res: '0};
    directed = {directed, row};
  endfunction

  function automatic void add_query(int sr, int sc, int gr, int gc, bit known,
                                    out_item_t res);
    in_item_t  q;
    step_row_t row;
    q = '{start_row: 3'(sr), start_col: 3'(sc), goal_row: 3'(gr), goal_col: 3'(gc)};
    row = '{is_cfg: 1'b0, idx: '0, data: '0, q: q, known: known, res: res};
    directed = {directed, row};
  endfunction

  // Hold off until every owed cell has come, then let the block settle
  task automatic drain();
    @(posedge clk);
    in_valid <= 1'b0;
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_GRID_ROWS:   shadow_rows = data[3:0];
      CFG_GRID_COLS:   shadow_cols = data[3:0];
      CFG_BLOCKED_MAP: shadow_blocked = data;
      default: ;
    endcase
  endtask

  // Present one query, hold it until the transaction, then queue its cells
  task automatic send_query(in_item_t q, bit known, out_item_t res);
    if ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    in_valid <= 1'b1;
    in_data  <= q;
    do @(posedge clk); while (!in_ready);
    if (known) owe_cell(res);
    else plan_path(q);
  endtask

  // Result side: check each transaction, then pick the next ready
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_cells.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %p", $time, out_data);
        errors++;
      end else begin
        want = expected_cells.pop_front();
        if (out_data !== want) begin
          $display("%0t mismatch: expected row %0d col %0d outcome %0d last %0d,",
                   $time, want.cell_row, want.cell_col, want.outcome, want.last_item);
          $display("%0t          actual   row %0d col %0d outcome %0d last %0d",
                   $time, out_data.cell_row, out_data.cell_col, out_data.outcome,
                   out_data.last_item);
          errors++;
        end
      end
    end
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL grid_astar_path_planner");
      $finish;
    end
  end

  initial begin
    in_item_t    q;
    logic [63:0] map;
    int          phase_gap [4];
    int          phase_stall [4];
    errors = 0;
    cycles = 0;
    gap_pct = 0;
    stall_pct = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    shadow_rows = 8;
    shadow_cols = 8;
    shadow_blocked = '0;
    phase_gap = '{0, 74, 0, 23};
    phase_stall = '{0, 0, 74, 23};

    // reset state: open 8 x 8 grid
    add_query(0, 0, 0, 0, 1, '{0, 0, OUTCOME_PATH, 1'b1});
    add_query(7, 7, 7, 7, 1, '{7, 7, OUTCOME_PATH, 1'b1});
    add_query(0, 0, 7, 7, 0, '0);
    add_query(7, 0, 0, 7, 0, '0);
    add_query(3, 4, 3, 5, 0, '0);
    // goal blocked: open set runs dry; start on a blocked cell still expands
    add_cfg(CFG_BLOCKED_MAP, 64'd1 << 63);
    add_query(0, 0, 7, 7, 1, '{0, 0, OUTCOME_NO_PATH, 1'b1});
    add_query(7, 7, 7, 7, 1, '{7, 7, OUTCOME_PATH, 1'b1});
    add_query(7, 7, 0, 0, 0, '0);
    // goal and start outside the used rows
    add_cfg(CFG_GRID_ROWS, 64'd4);
    add_query(0, 0, 5, 5, 1, '{0, 0, OUTCOME_NO_PATH, 1'b1});
    add_query(6, 6, 0, 0, 0, '0);
    // zero rows: nothing is free to move into
    add_cfg(CFG_GRID_ROWS, 64'd0);
    add_query(0, 0, 1, 1, 1, '{0, 0, OUTCOME_NO_PATH, 1'b1});
    // rows above the side clamp to 8; single column
    add_cfg(CFG_GRID_ROWS, 64'd15);
    add_cfg(CFG_GRID_COLS, 64'd1);
    add_query(0, 0, 6, 0, 0, '0);
    add_cfg(CFG_GRID_COLS, 64'd8);
    add_cfg(CFG_BLOCKED_MAP, '1);
    add_query(0, 0, 0, 1, 1, '{0, 0, OUTCOME_NO_PATH, 1'b1});
    // write past the register list must not disturb the map
    add_cfg(CFG_UNUSED, '0);
    add_query(3, 3, 3, 4, 1, '{0, 0, OUTCOME_NO_PATH, 1'b1});
    // wall on column 3 with a gap in the bottom row
    add_cfg(CFG_BLOCKED_MAP, 64'h0008_0808_0808_0808);
    add_query(0, 0, 0, 7, 0, '0);
    add_cfg(CFG_BLOCKED_MAP, 64'd0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        drain();
        cfg_write(directed[i].idx, directed[i].data);
      end else begin
        send_query(directed[i].q, directed[i].known, directed[i].res);
      end
    end

    // Random phases, one per idling mode; the drain also pauses the sender
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      gap_pct = phase_gap[ph];
      stall_pct = phase_stall[ph];
      cfg_write(CFG_GRID_ROWS, ($urandom_range(3) == 0) ? $urandom_range(15) : 8);
      cfg_write(CFG_GRID_COLS, ($urandom_range(3) == 0) ? $urandom_range(15) : 8);
      map = {$urandom, $urandom} & {$urandom, $urandom};
      if (ph != 3) map = map & {$urandom, $urandom};
      cfg_write(CFG_BLOCKED_MAP, map);
      for (int n = 0; n < 32; n++) begin
        q = in_item_t'(12'($urandom));
        send_query(q, 1'b0, '0);
      end
    end

    drain();
    if (errors == 0 && expected_cells.size() == 0) begin
      $display("PASS grid_astar_path_planner");
    end else begin
      $display("FAIL grid_astar_path_planner");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/gap_pkg.sv
hdl/gap_datapath.sv
hdl/gap_ctrl.sv
hdl/grid_astar_path_planner.sv
tb/sv/tb_grid_astar_path_planner.sv
